// ===== hdl/hrfv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hrfv_pkg;

  // default store depth
  localparam int REG_COUNT_DEF = 16;
  // staging buffer depth and longest reply
  localparam int BUF_DEPTH = 16;
  localparam int BUF_AW    = 4;

  localparam int WORD_W  = 16;
  localparam int COUNT_W = 7;
  localparam int LIMIT_W = 5;
  localparam int CFG_AW  = 2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_REGS_IN_USE   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_READONLY_MASK = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MAX_VALUE     = 2'd2;

  // configuration reset values
  localparam logic [LIMIT_W-1:0] REGS_IN_USE_RST   = 5'd10;
  localparam logic [WORD_W-1:0]  READONLY_MASK_RST = 16'h0001;
  localparam logic [WORD_W-1:0]  MAX_VALUE_RST     = 16'd1000;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 7'd127;

  // operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ADDR = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FINISH,
    S_CHK_RD,
    S_CHK_CMP,
    S_COM_RD,
    S_COM_WR
  } state_t;

  // base + count must stay within the reachable limit
  function automatic logic in_range(input logic [WORD_W-1:0] base,
                                    input logic [COUNT_W-1:0] count,
                                    input logic [LIMIT_W-1:0] limit);
    logic [WORD_W:0] sum;
    sum = {1'b0, base} + {{(WORD_W+1-COUNT_W){1'b0}}, count};
    return sum <= {{(WORD_W+1-LIMIT_W){1'b0}}, limit};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/holding_register_file_validated_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// holding register area with validated writes
//
// input channel: an item transfers at a rising edge with start high and busy low.
// a read request is one item; it returns one result per word, end_of_reply on
// the last, or a single result for a zero count or an illegal address.
// a write request is one item per data word; items before the one with last
// set give no result, the last one gives a single status result.
// results: out_strobe marks each result for exactly one cycle; the receiver
// must take it then, it cannot stall the block.
// config: cfg_valid/cfg_ready write channel, always ready; write only while idle.
// a read puts its first word on the ports through the store's registered read
// port, then one word per cycle, busy until its last word. a single
// result comes in the cycle after the transfer and busy stays low.
// a write word that is not last leaves busy low. the last word keeps busy high
// for the address and count check, then (unless a check fails) a staging read
// and a compare step per word for the staged value and read-only check (the
// staging buffer has a registered read port), then a staging read and a store
// write per word for the commit; its status follows in the next cycle.
// reset (synchronous, rst_n low): store entry i reads as i (valid bits, no
// clearing pass), configuration back to 10 / 0x0001 / 1000, sequencer idle.
module holding_register_file_validated_unit #(
  parameter int REG_COUNT = hrfv_pkg::REG_COUNT_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // request channel
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  in_operation,
  input  wire  [hrfv_pkg::WORD_W-1:0]          in_start_address,
  input  wire  [hrfv_pkg::COUNT_W-1:0]         in_word_count,
  input  wire  [hrfv_pkg::WORD_W-1:0]          in_data_word,
  input  wire                                  in_last,
  // result channel
  output logic                                 out_strobe,
  output logic [1:0]                           out_status,
  output logic [hrfv_pkg::WORD_W-1:0]          out_read_word,
  output logic                                 out_end_of_reply,
  // configuration channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [hrfv_pkg::CFG_AW-1:0]          cfg_index,
  input  wire  [hrfv_pkg::WORD_W-1:0]          cfg_data
);

  localparam int AW      = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int LIM_CAP = (REG_COUNT < hrfv_pkg::BUF_DEPTH) ? REG_COUNT
                                                             : hrfv_pkg::BUF_DEPTH;

  // configuration registers
  logic [hrfv_pkg::LIMIT_W-1:0] regs_in_use_r;
  logic [hrfv_pkg::WORD_W-1:0]  readonly_mask_r;
  logic [hrfv_pkg::WORD_W-1:0]  max_value_r;

  // sequencer and request state
  hrfv_pkg::state_t             state_r, state_nxt;
  logic                         in_wr_r, in_wr_nxt;
  logic [hrfv_pkg::WORD_W-1:0]  base_r, base_nxt;
  logic [hrfv_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [hrfv_pkg::COUNT_W-1:0] words_r, words_nxt;
  logic [hrfv_pkg::BUF_AW-1:0]  idx_r, idx_nxt;

  // result registers
  logic                         strobe_r, strobe_nxt;
  hrfv_pkg::status_t            status_r, status_nxt;
  logic                         end_r, end_nxt;
  logic                         pend_r, pend_nxt;

  // store and staging buffer
  logic [hrfv_pkg::WORD_W-1:0]  store_mem [REG_COUNT];
  logic [REG_COUNT-1:0]         store_vld_r;
  logic [hrfv_pkg::WORD_W-1:0]  store_rdata_r;
  logic [hrfv_pkg::WORD_W-1:0]  stg_mem [hrfv_pkg::BUF_DEPTH];
  logic [hrfv_pkg::WORD_W-1:0]  stg_rdata_r;

  logic                         accept;
  logic [hrfv_pkg::LIMIT_W-1:0] limit;
  logic [hrfv_pkg::WORD_W-1:0]  in_base;
  logic [hrfv_pkg::WORD_W-1:0]  base_eff;
  logic [hrfv_pkg::COUNT_W-1:0] cnt_eff;
  logic [hrfv_pkg::COUNT_W-1:0] words_eff;
  logic [hrfv_pkg::COUNT_W-1:0] words_inc;
  logic                         rd_ok;
  logic                         wr_ok;
  logic                         last_idx;
  logic [hrfv_pkg::WORD_W-1:0]  abs_addr;
  logic [AW-1:0]                st_addr;
  logic                         item_fail;
  logic                         stg_we;
  logic                         stg_re;
  logic                         st_we;
  logic                         st_re;

  assign accept    = start && !busy;
  assign busy      = (state_r != hrfv_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // reachable limit, capped by store and staging depth
  assign limit = (regs_in_use_r > hrfv_pkg::LIMIT_W'(LIM_CAP))
                 ? hrfv_pkg::LIMIT_W'(LIM_CAP) : regs_in_use_r;

  // one-based to zero-based, wraps so address zero lands out of range
  assign in_base = in_start_address - 16'd1;

  // a fresh write request takes its base and count from this item
  assign base_eff  = in_wr_r ? base_r : in_base;
  assign cnt_eff   = in_wr_r ? cnt_r : in_word_count;
  assign words_eff = in_wr_r ? words_r : '0;
  assign words_inc = (words_eff == hrfv_pkg::COUNT_SAT) ? words_eff
                                                       : words_eff + 7'd1;

  assign rd_ok = hrfv_pkg::in_range(in_base, in_word_count, limit);
  assign wr_ok = hrfv_pkg::in_range(base_r, cnt_r, limit);

  assign last_idx = ({{(hrfv_pkg::COUNT_W-hrfv_pkg::BUF_AW){1'b0}}, idx_r} + 7'd1
                     == cnt_r);
  assign abs_addr = base_r + {{(hrfv_pkg::WORD_W-hrfv_pkg::BUF_AW){1'b0}}, idx_r};
  assign st_addr  = abs_addr[AW-1:0];

  // range already checked, so the target is below sixteen
  assign item_fail = readonly_mask_r[abs_addr[hrfv_pkg::BUF_AW-1:0]] ||
                     (stg_rdata_r > max_value_r);

  // staging write: only words inside the count and the buffer
  assign stg_we = accept && (in_operation == hrfv_pkg::OP_WRITE) &&
                  (words_eff < cnt_eff) &&
                  (words_eff < 7'(hrfv_pkg::BUF_DEPTH));
  assign stg_re = (state_r == hrfv_pkg::S_CHK_RD) || (state_r == hrfv_pkg::S_COM_RD);
  assign st_re  = (state_r == hrfv_pkg::S_READ);
  assign st_we  = (state_r == hrfv_pkg::S_COM_WR);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hrfv_pkg::S_IDLE: begin
        if (accept) begin
          if (in_operation == hrfv_pkg::OP_READ) begin
            if (rd_ok && (in_word_count != '0)) state_nxt = hrfv_pkg::S_READ;
          end else if (in_last) begin
            state_nxt = hrfv_pkg::S_FINISH;
          end
        end
      end
      hrfv_pkg::S_READ: begin
        if (last_idx) state_nxt = hrfv_pkg::S_IDLE;
      end
      hrfv_pkg::S_FINISH: begin
        if (!wr_ok || (words_r != cnt_r)) state_nxt = hrfv_pkg::S_IDLE;
        else state_nxt = hrfv_pkg::S_CHK_RD;
      end
      hrfv_pkg::S_CHK_RD: state_nxt = hrfv_pkg::S_CHK_CMP;
      hrfv_pkg::S_CHK_CMP: begin
        if (item_fail) state_nxt = hrfv_pkg::S_IDLE;
        else if (last_idx) state_nxt = hrfv_pkg::S_COM_RD;
        else state_nxt = hrfv_pkg::S_CHK_RD;
      end
      hrfv_pkg::S_COM_RD: state_nxt = hrfv_pkg::S_COM_WR;
      hrfv_pkg::S_COM_WR: begin
        if (last_idx) state_nxt = hrfv_pkg::S_IDLE;
        else state_nxt = hrfv_pkg::S_COM_RD;
      end
      default: state_nxt = hrfv_pkg::S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    in_wr_nxt  = in_wr_r;
    base_nxt   = base_r;
    cnt_nxt    = cnt_r;
    words_nxt  = words_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    end_nxt    = end_r;
    pend_nxt   = 1'b0;
    case (state_r)
      hrfv_pkg::S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (in_operation == hrfv_pkg::OP_READ) begin
            // a read drops any pending write
            in_wr_nxt = 1'b0;
            words_nxt = '0;
            base_nxt  = in_base;
            cnt_nxt   = in_word_count;
            if (!rd_ok) begin
              strobe_nxt = 1'b1;
              status_nxt = hrfv_pkg::ST_ADDR;
              end_nxt    = 1'b1;
            end else if (in_word_count == '0) begin
              strobe_nxt = 1'b1;
              status_nxt = hrfv_pkg::ST_OK;
              end_nxt    = 1'b1;
            end
          end else begin
            base_nxt  = base_eff;
            cnt_nxt   = cnt_eff;
            words_nxt = words_inc;
            in_wr_nxt = !in_last;
          end
        end
      end
      hrfv_pkg::S_READ: begin
        strobe_nxt = 1'b1;
        pend_nxt   = 1'b1;
        status_nxt = hrfv_pkg::ST_OK;
        end_nxt    = last_idx;
        idx_nxt    = idx_r + 4'd1;
      end
      hrfv_pkg::S_FINISH: begin
        words_nxt = '0;
        if (!wr_ok) begin
          strobe_nxt = 1'b1;
          status_nxt = hrfv_pkg::ST_ADDR;
          end_nxt    = 1'b1;
        end else if (words_r != cnt_r) begin
          strobe_nxt = 1'b1;
          status_nxt = hrfv_pkg::ST_FAIL;
          end_nxt    = 1'b1;
        end
      end
      hrfv_pkg::S_CHK_CMP: begin
        if (item_fail) begin
          strobe_nxt = 1'b1;
          status_nxt = hrfv_pkg::ST_FAIL;
          end_nxt    = 1'b1;
        end else if (last_idx) begin
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      hrfv_pkg::S_COM_WR: begin
        idx_nxt = idx_r + 4'd1;
        if (last_idx) begin
          strobe_nxt = 1'b1;
          status_nxt = hrfv_pkg::ST_OK;
          end_nxt    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= hrfv_pkg::S_IDLE;
      in_wr_r         <= 1'b0;
      base_r          <= '0;
      cnt_r           <= '0;
      words_r         <= '0;
      idx_r           <= '0;
      strobe_r        <= 1'b0;
      status_r        <= hrfv_pkg::ST_OK;
      end_r           <= 1'b0;
      pend_r          <= 1'b0;
      regs_in_use_r   <= hrfv_pkg::REGS_IN_USE_RST;
      readonly_mask_r <= hrfv_pkg::READONLY_MASK_RST;
      max_value_r     <= hrfv_pkg::MAX_VALUE_RST;
      store_vld_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      in_wr_r  <= in_wr_nxt;
      base_r   <= base_nxt;
      cnt_r    <= cnt_nxt;
      words_r  <= words_nxt;
      idx_r    <= idx_nxt;
      strobe_r <= strobe_nxt;
      status_r <= status_nxt;
      end_r    <= end_nxt;
      pend_r   <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hrfv_pkg::CFG_REGS_IN_USE:   regs_in_use_r   <= cfg_data[hrfv_pkg::LIMIT_W-1:0];
          hrfv_pkg::CFG_READONLY_MASK: readonly_mask_r <= cfg_data;
          hrfv_pkg::CFG_MAX_VALUE:     max_value_r     <= cfg_data;
          default: ;
        endcase
      end
      if (st_we) store_vld_r[st_addr] <= 1'b1;
    end
  end

  // holding store, entries not yet written read as their own index
  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_addr] <= stg_rdata_r;
    if (st_re) store_rdata_r <= store_vld_r[st_addr] ? store_mem[st_addr]
                                                      : hrfv_pkg::WORD_W'(st_addr);
  end

  // staging buffer
  always_ff @(posedge clk) begin
    if (stg_we) stg_mem[words_eff[hrfv_pkg::BUF_AW-1:0]] <= in_data_word;
    if (stg_re) stg_rdata_r <= stg_mem[idx_r];
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_end_of_reply = end_r;
  assign out_read_word    = pend_r ? store_rdata_r : '0;

  // a read burst has no gaps until its last word
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_end_of_reply) |=> out_strobe)
    else $error("read burst broken before its last word");

  // error results always close the reply
  a_error_ends_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != hrfv_pkg::ST_OK)) |-> out_end_of_reply)
    else $error("error result without end of reply");

  // error results carry a zero word; only read words carry data
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != hrfv_pkg::ST_OK)) |-> (out_read_word == '0))
    else $error("nonzero word on an error result");

  // no write request stays open while the sequencer runs
  a_no_open_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != hrfv_pkg::S_IDLE) |-> !in_wr_r)
    else $error("write request still open while busy");

endmodule

`default_nettype wire

// ===== tb/holding_register_file_validated_unit_tb.sv =====
`timescale 1ns / 1ps

module holding_register_file_validated_unit_tb;

  localparam int CYCLE_LIMIT  = 400000;
  // tail wait, longer than the longest last-word commit
  localparam int TAIL_CYCLES  = 80;
  localparam int SETTLE_LIMIT = 5000;
  localparam int PRINT_LIMIT  = 100;
  // the one index the block does not decode
  localparam logic [hrfv_pkg::CFG_AW-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    hrfv_pkg::status_t                   status;
    logic [hrfv_pkg::WORD_W-1:0]         word;
    logic                                last_word;
  } reply_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // request side
  logic                          start            = 1'b0;
  logic                          busy;
  logic                          in_operation     = hrfv_pkg::OP_READ;
  logic [hrfv_pkg::WORD_W-1:0]   in_start_address = '0;
  logic [hrfv_pkg::COUNT_W-1:0]  in_word_count    = '0;
  logic [hrfv_pkg::WORD_W-1:0]   in_data_word     = '0;
  logic                          in_last          = 1'b0;

  // reply side
  logic                          out_strobe;
  logic [1:0]                    out_status;
  logic [hrfv_pkg::WORD_W-1:0]   out_read_word;
  logic                          out_end_of_reply;

  // register write side
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [hrfv_pkg::CFG_AW-1:0]   cfg_index = '0;
  logic [hrfv_pkg::WORD_W-1:0]   cfg_data  = '0;

  // predicted block state
  logic [hrfv_pkg::WORD_W-1:0]   store_image [hrfv_pkg::BUF_DEPTH];
  logic [hrfv_pkg::WORD_W-1:0]   staged_words [hrfv_pkg::BUF_DEPTH];
  logic [hrfv_pkg::WORD_W-1:0]   req_base;
  logic [hrfv_pkg::COUNT_W-1:0]  req_count;
  logic [hrfv_pkg::COUNT_W-1:0]  words_in;
  logic                          write_open;
  logic [hrfv_pkg::LIMIT_W-1:0]  lim_regs;
  logic [hrfv_pkg::WORD_W-1:0]   ro_mask;
  logic [hrfv_pkg::WORD_W-1:0]   max_word;

  reply_t expected_replies [$];

  // words of the next write request, first word at index 0
  logic [hrfv_pkg::WORD_W-1:0]   burst_words [0:143];

  int  errors      = 0;
  int  items_sent  = 0;
  int  cycle_count = 0;
  bit  idle_enable = 1'b0;
  bit  phase_gaps  = 1'b0;

  always #4 clk = ~clk;

  holding_register_file_validated_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_start_address (in_start_address),
    .in_word_count    (in_word_count),
    .in_data_word     (in_data_word),
    .in_last          (in_last),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_read_word    (out_read_word),
    .out_end_of_reply (out_end_of_reply),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  task automatic report_mismatch(input string what,
                                 input logic [hrfv_pkg::WORD_W-1:0] got,
                                 input logic [hrfv_pkg::WORD_W-1:0] want);
    if (errors < PRINT_LIMIT) begin
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    end
    errors++;
  endtask

  // number of store entries a request may touch
  function automatic int reach_now();
    return (lim_regs > hrfv_pkg::BUF_DEPTH) ? hrfv_pkg::BUF_DEPTH : int'(lim_regs);
  endfunction

  function automatic bit fits(input logic [hrfv_pkg::WORD_W-1:0] base,
                              input logic [hrfv_pkg::COUNT_W-1:0] cnt);
    return int'(base) + int'(cnt) <= reach_now();
  endfunction

  function automatic logic [hrfv_pkg::WORD_W-1:0] pick_value();
    // mostly storable values, some above the limit
    return ($urandom_range(0, 3) != 0) ? hrfv_pkg::WORD_W'($urandom_range(0, max_word))
                                       : hrfv_pkg::WORD_W'($urandom);
  endfunction

  task automatic expect_reply(input hrfv_pkg::status_t st,
                              input logic [hrfv_pkg::WORD_W-1:0] w, input logic e);
    reply_t r;
    r.status    = st;
    r.word      = w;
    r.last_word = e;
    expected_replies.push_back(r);
  endtask

  task automatic reset_model();
    for (int i = 0; i < hrfv_pkg::BUF_DEPTH; i++) begin
      store_image[i]  = hrfv_pkg::WORD_W'(i);
      staged_words[i] = '0;
    end
    req_base   = '0;
    req_count  = '0;
    words_in   = '0;
    write_open = 1'b0;
    lim_regs   = hrfv_pkg::REGS_IN_USE_RST;
    ro_mask    = hrfv_pkg::READONLY_MASK_RST;
    max_word   = hrfv_pkg::MAX_VALUE_RST;
  endtask

  // replies caused by one accepted item, and the state change it makes
  task automatic predict_replies(input logic op, input logic [hrfv_pkg::WORD_W-1:0] addr,
                                 input logic [hrfv_pkg::COUNT_W-1:0] cnt,
                                 input logic [hrfv_pkg::WORD_W-1:0] data, input logic last);
    hrfv_pkg::status_t verdict;
    if (op == hrfv_pkg::OP_READ) begin
      // a read also drops any write still being collected
      write_open = 1'b0;
      words_in   = '0;
      req_base   = addr - 16'd1;
      req_count  = cnt;
      if (!fits(req_base, cnt)) begin
        expect_reply(hrfv_pkg::ST_ADDR, '0, 1'b1);
      end else if (cnt == 0) begin
        expect_reply(hrfv_pkg::ST_OK, '0, 1'b1);
      end else begin
        for (int i = 0; i < cnt; i++) begin
          expect_reply(hrfv_pkg::ST_OK, store_image[int'(req_base) + i], i == cnt - 1);
        end
      end
    end else begin
      // address and count come from the first word only
      if (!write_open) begin
        write_open = 1'b1;
        req_base   = addr - 16'd1;
        req_count  = cnt;
        words_in   = '0;
      end
      if (words_in < req_count && words_in < hrfv_pkg::BUF_DEPTH) begin
        staged_words[words_in] = data;
      end
      if (words_in < hrfv_pkg::COUNT_SAT) begin
        words_in++;
      end
      if (last) begin
        verdict = hrfv_pkg::ST_OK;
        if (!fits(req_base, req_count)) begin
          verdict = hrfv_pkg::ST_ADDR;
        end else if (words_in != req_count) begin
          verdict = hrfv_pkg::ST_FAIL;
        end else begin
          for (int i = 0; i < req_count; i++) begin
            if (ro_mask[int'(req_base) + i] || staged_words[i] > max_word) begin
              verdict = hrfv_pkg::ST_FAIL;
            end
          end
          // all or nothing
          if (verdict == hrfv_pkg::ST_OK) begin
            for (int i = 0; i < req_count; i++) begin
              store_image[int'(req_base) + i] = staged_words[i];
            end
          end
        end
        expect_reply(verdict, '0, 1'b1);
        write_open = 1'b0;
        words_in   = '0;
      end
    end
  endtask

  // one item transfer; start stays high so a following item goes out back to back
  task automatic issue_item(input logic op, input logic [hrfv_pkg::WORD_W-1:0] addr,
                            input logic [hrfv_pkg::COUNT_W-1:0] cnt,
                            input logic [hrfv_pkg::WORD_W-1:0] data, input logic last);
    start            <= 1'b1;
    in_operation     <= op;
    in_start_address <= addr;
    in_word_count    <= cnt;
    in_data_word     <= data;
    in_last          <= last;
    do @(posedge clk); while (busy !== 1'b0);
    predict_replies(op, addr, cnt, data, last);
    items_sent++;
    // random sender gap after the transfer
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic read_req(input logic [hrfv_pkg::WORD_W-1:0] addr,
                          input logic [hrfv_pkg::COUNT_W-1:0] cnt);
    // data and last mean nothing on a read, so they get noise
    issue_item(hrfv_pkg::OP_READ, addr, cnt, hrfv_pkg::WORD_W'($urandom), 1'($urandom));
  endtask

  // n words from burst_words; later words carry noise in the address and count
  task automatic write_req(input logic [hrfv_pkg::WORD_W-1:0] addr,
                           input logic [hrfv_pkg::COUNT_W-1:0] cnt,
                           input int n, input bit close);
    for (int i = 0; i < n; i++) begin
      issue_item(hrfv_pkg::OP_WRITE, (i == 0) ? addr : hrfv_pkg::WORD_W'($urandom),
                 (i == 0) ? cnt : hrfv_pkg::COUNT_W'($urandom), burst_words[i],
                 close && (i == n - 1));
    end
  endtask

  // wait out every expected reply, then the block's longest tail
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while ((expected_replies.size() != 0 || busy !== 1'b0) && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_replies.size() != 0) begin
      report_mismatch("replies never arrived",
                      hrfv_pkg::WORD_W'(expected_replies.size()), '0);
      expected_replies.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [hrfv_pkg::CFG_AW-1:0] idx,
                              input logic [hrfv_pkg::WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      hrfv_pkg::CFG_REGS_IN_USE:   lim_regs = value[hrfv_pkg::LIMIT_W-1:0];
      hrfv_pkg::CFG_READONLY_MASK: ro_mask  = value;
      hrfv_pkg::CFG_MAX_VALUE:     max_word = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_config(input logic [hrfv_pkg::LIMIT_W-1:0] regs,
                            input logic [hrfv_pkg::WORD_W-1:0] mask,
                            input logic [hrfv_pkg::WORD_W-1:0] maxv);
    write_config(hrfv_pkg::CFG_REGS_IN_USE, hrfv_pkg::WORD_W'(regs));
    write_config(hrfv_pkg::CFG_READONLY_MASK, mask);
    write_config(hrfv_pkg::CFG_MAX_VALUE, maxv);
  endtask

  // reset contents, address wrap, zero count, range edge
  task automatic test_reset_state();
    idle_enable = 1'b1;
    read_req(16'd1, 7'd10);
    read_req(16'd0, 7'd1);
    read_req(16'd1, 7'd0);
    read_req(16'd10, 7'd1);
    read_req(16'd11, 7'd1);
    read_req(16'hFFFF, 7'd127);
    settle();
  endtask

  // read-only target, value limit, commit, count mismatch, read dropping a write
  task automatic test_write_rules();
    idle_enable = 1'b1;
    burst_words[0] = 16'd5;
    write_req(16'd1, 7'd1, 1, 1'b1);
    burst_words[0] = 16'd1000;
    burst_words[1] = 16'd1001;
    write_req(16'd2, 7'd2, 2, 1'b1);
    burst_words[1] = 16'd0;
    burst_words[2] = 16'd7;
    write_req(16'd2, 7'd3, 3, 1'b1);
    read_req(16'd1, 7'd5);
    // fewer words than the count, then more
    burst_words[0] = 16'd1;
    burst_words[1] = 16'd2;
    write_req(16'd5, 7'd2, 1, 1'b1);
    write_req(16'd5, 7'd1, 2, 1'b1);
    // a zero count write still carries a word
    write_req(16'd5, 7'd0, 1, 1'b1);
    write_req(16'd10, 7'd2, 2, 1'b1);
    write_req(16'd0, 7'd1, 1, 1'b1);
    // pending write dropped by a read, with no reply of its own
    burst_words[0] = 16'd11;
    write_req(16'd6, 7'd2, 1, 1'b0);
    read_req(16'd6, 7'd1);
    burst_words[0] = 16'd12;
    write_req(16'd6, 7'd1, 1, 1'b1);
    read_req(16'd6, 7'd1);
    settle();
  endtask

  // full store, saturated limit, smallest limit, unused index
  task automatic test_config_extremes();
    idle_enable = 1'b1;
    set_config(5'd16, 16'h0000, 16'hFFFF);
    for (int i = 0; i < hrfv_pkg::BUF_DEPTH; i++) begin
      burst_words[i] = hrfv_pkg::WORD_W'($urandom);
    end
    burst_words[0]  = 16'hFFFF;
    burst_words[15] = 16'h0000;
    write_req(16'd1, 7'd16, 16, 1'b1);
    read_req(16'd1, 7'd16);
    settle();
    write_config(CFG_UNUSED, 16'hFFFF);
    set_config(5'd31, 16'h8000, 16'hFFFF);
    read_req(16'd16, 7'd1);
    read_req(16'd16, 7'd2);
    burst_words[0] = 16'd3;
    write_req(16'd16, 7'd1, 1, 1'b1);
    settle();
    set_config(5'd1, 16'hFFFF, 16'd0);
    burst_words[0] = 16'd0;
    write_req(16'd1, 7'd1, 1, 1'b1);
    read_req(16'd1, 7'd1);
    read_req(16'd2, 7'd1);
    settle();
  endtask

  // received word total must stop at 127 rather than wrap to the zero count
  task automatic test_count_saturation();
    idle_enable = 1'b0;
    set_config(hrfv_pkg::REGS_IN_USE_RST, hrfv_pkg::READONLY_MASK_RST,
               hrfv_pkg::MAX_VALUE_RST);
    for (int i = 0; i < 130; i++) begin
      burst_words[i] = hrfv_pkg::WORD_W'($urandom);
    end
    write_req(16'd2, 7'd0, 130, 1'b1);
    settle();
  endtask

  // one random request: mostly well formed, some broken or noise
  task automatic random_request();
    int reach, base, cnt, n, kind;
    reach = reach_now();
    kind  = $urandom_range(0, 99);
    base  = $urandom_range(0, reach - 1);
    idle_enable = phase_gaps && ($urandom_range(0, 3) != 0);
    if (kind < 30) begin
      if ($urandom_range(0, 9) == 0) begin
        read_req(hrfv_pkg::WORD_W'($urandom), hrfv_pkg::COUNT_W'($urandom));
      end else begin
        read_req(hrfv_pkg::WORD_W'(base + 1),
                 hrfv_pkg::COUNT_W'($urandom_range(0, reach - base)));
      end
    end else if (kind < 85) begin
      cnt = $urandom_range(1, reach - base);
      for (int i = 0; i < cnt; i++) begin
        burst_words[i] = pick_value();
      end
      write_req(hrfv_pkg::WORD_W'(base + 1), hrfv_pkg::COUNT_W'(cnt), cnt, 1'b1);
    end else if (kind < 92) begin
      // one word too many or too few
      cnt = $urandom_range(0, reach - base);
      n   = (cnt < 2 || $urandom_range(0, 1) == 0) ? cnt + 1 : cnt - 1;
      for (int i = 0; i < n; i++) begin
        burst_words[i] = pick_value();
      end
      write_req(hrfv_pkg::WORD_W'(base + 1), hrfv_pkg::COUNT_W'(cnt), n, 1'b1);
    end else if (kind < 96) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        burst_words[i] = hrfv_pkg::WORD_W'($urandom);
      end
      write_req(hrfv_pkg::WORD_W'($urandom), hrfv_pkg::COUNT_W'($urandom), n, 1'b1);
    end else begin
      // write cut short by a read
      cnt = $urandom_range(1, reach - base);
      n   = $urandom_range(1, cnt);
      for (int i = 0; i < n; i++) begin
        burst_words[i] = pick_value();
      end
      write_req(hrfv_pkg::WORD_W'(base + 1), hrfv_pkg::COUNT_W'(cnt), n, 1'b0);
      read_req(hrfv_pkg::WORD_W'(base + 1),
               hrfv_pkg::COUNT_W'($urandom_range(0, reach - base)));
    end
  endtask

  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(5'd10, 16'h0001, 16'd1000);
        1: set_config(5'd16, 16'h0000, 16'hFFFF);
        2: set_config(5'd31, hrfv_pkg::WORD_W'($urandom & $urandom),
                      hrfv_pkg::WORD_W'($urandom));
        3: set_config(5'd1, 16'hFFFF, 16'd0);
        default: set_config(hrfv_pkg::LIMIT_W'($urandom_range(1, 16)),
                            hrfv_pkg::WORD_W'($urandom & $urandom & $urandom),
                            hrfv_pkg::WORD_W'($urandom_range(0, 2000)));
      endcase
      // the last phase runs without sender gaps
      phase_gaps = (phase != 4);
      target = items_sent + ((phase == 3) ? 2 : 4);
      while (items_sent < target) begin
        random_request();
      end
      settle();
    end
  endtask

  // reply checker: every strobe must match the oldest prediction
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with none expected", out_read_word, '0);
      end else begin
        want = expected_replies.pop_front();
        if (out_status !== want.status) begin
          report_mismatch("status", hrfv_pkg::WORD_W'(out_status),
                          hrfv_pkg::WORD_W'(want.status));
        end
        if (out_read_word !== want.word) begin
          report_mismatch("read_word", out_read_word, want.word);
        end
        if (out_end_of_reply !== want.last_word) begin
          report_mismatch("end_of_reply", hrfv_pkg::WORD_W'(out_end_of_reply),
                          hrfv_pkg::WORD_W'(want.last_word));
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_write_rules();
    test_config_extremes();
    test_count_saturation();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hrfv_pkg.sv
hdl/holding_register_file_validated_unit.sv
tb/holding_register_file_validated_unit_tb.sv
